// File: design/lav_pkg.sv
`timescale 1ns / 1ps

package lav_pkg;

   localparam int IN_W    = 32;
   localparam int IN_N    = 9;
   localparam int REQ_W   = IN_W * IN_N;
   localparam int RSP_W   = 4 * IN_W;
   localparam int USER_W  = 3;
   localparam int MAG_W   = 52;
   localparam int POS_W   = $clog2(MAG_W);
   localparam int SCL_W   = 30;
   localparam int SQR_W   = 2 * SCL_W;
   localparam int SUM_W   = 62;
   localparam int ROOT_W  = 31;
   localparam int QUO_W   = 17;
   localparam int NUM_W   = SCL_W + 16 + 1;
   localparam int UNIT_W  = 18;
   localparam int SIDE_W  = 192;
   localparam int NSQ_ST  = (ROOT_W + 1) / 2;
   localparam int NDIV_ST = (QUO_W + 1) / 2;

   localparam logic [1:0]      ROW_FIRST = 2'd0;
   localparam logic [1:0]      ROW_LAST  = 2'd3;
   localparam logic [IN_W-1:0] ONE_Q16   = 32'h0001_0000;

   typedef logic [2:0][MAG_W-1:0]  mag3_type;
   typedef logic [2:0][UNIT_W-1:0] unit3_type;
   typedef logic [2:0][IN_W-1:0]   vec3_type;
   typedef logic [SIDE_W-1:0]      side_type;

endpackage

// File: design/lav_norm.sv
`timescale 1ns / 1ps

module lav_norm (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  lav_pkg::mag3_type  in_mag,
   input  logic [2:0]         in_neg,
   input  lav_pkg::side_type  in_side,
   output logic               out_valid,
   output lav_pkg::unit3_type out_unit,
   output logic               out_zero,
   output lav_pkg::side_type  out_side
);
   import lav_pkg::*;

   typedef struct packed {
      logic [2:0][SCL_W-1:0] m;
      logic [2:0]            neg;
      logic                  zero;
      side_type              side;
      logic [SUM_W-1:0]      rem;
      logic [ROOT_W-1:0]     root;
   } sq_type;

   typedef struct packed {
      logic [ROOT_W-1:0]            len;
      logic [2:0][ROOT_W-1:0]       rem;
      logic [2:0][QUO_W-1:0]        q;
      logic [2:0][QUO_W-1:0]        nlo;
      logic [2:0]                   neg;
      logic                         zero;
      side_type                     side;
   } dv_type;

   function automatic logic [POS_W-1:0] msb_pos(input logic [MAG_W-1:0] v);
      logic [POS_W-1:0] p;
      p = '0;
      for (int i = 0; i < MAG_W; i++) begin
         if (v[i]) begin
            p = POS_W'(i);
         end
      end
      return p;
   endfunction

   function automatic sq_type sqrt_bit(input sq_type a, input int b);
      sq_type         r;
      logic [SUM_W:0] cand;
      r = a;
      cand = ({{(SUM_W + 1 - ROOT_W){1'b0}}, a.root} << (b + 1))
           + ({{SUM_W{1'b0}}, 1'b1} << (2 * b));
      if ({1'b0, a.rem} >= cand) begin
         r.rem  = a.rem - cand[SUM_W-1:0];
         r.root = a.root | ({{(ROOT_W - 1){1'b0}}, 1'b1} << b);
      end
      return r;
   endfunction

   function automatic sq_type sqrt_pair(input sq_type a, input int k);
      sq_type r;
      int     b;
      b = ROOT_W - 1 - 2 * k;
      r = sqrt_bit(a, b);
      if (b >= 1) begin
         r = sqrt_bit(r, b - 1);
      end
      return r;
   endfunction

   function automatic dv_type div_bit(input dv_type a, input int i);
      dv_type          r;
      logic [ROOT_W:0] t;
      r = a;
      for (int j = 0; j < 3; j++) begin
         t = {a.rem[j], a.nlo[j][QUO_W-1-i]};
         if (t >= {1'b0, a.len}) begin
            t = t - {1'b0, a.len};
            r.q[j][QUO_W-1-i] = 1'b1;
         end
         r.rem[j] = t[ROOT_W-1:0];
      end
      return r;
   endfunction

   function automatic dv_type div_pair(input dv_type a, input int k);
      dv_type r;
      r = div_bit(a, 2 * k);
      if (2 * k + 1 < QUO_W) begin
         r = div_bit(r, 2 * k + 1);
      end
      return r;
   endfunction

   logic [3:0]            v_ff;
   logic [NSQ_ST:0]       sqv_ff;
   logic [NDIV_ST:0]      dvv_ff;
   logic                  out_valid_ff;

   mag3_type              mag0_ff, mag1_ff;
   logic [2:0]            neg0_ff, neg1_ff, neg2_ff, neg3_ff;
   side_type              side0_ff, side1_ff, side2_ff, side3_ff;
   logic [MAG_W-1:0]      mx1_in, mx1_ff;
   logic                  zero1_ff, zero2_ff, zero3_ff;
   logic [2:0][SCL_W-1:0] scl2_in, scl2_ff, scl3_ff;
   logic [2:0][SQR_W-1:0] sqr3_ff;
   logic [POS_W-1:0]      p2;
   sq_type                sq0_in;
   sq_type                sq_ff [NSQ_ST+1];
   dv_type                dv0_in;
   dv_type                dv_ff [NDIV_ST+1];
   logic [2:0][NUM_W-1:0] num;
   unit3_type             out_unit_in, out_unit_ff;
   logic                  out_zero_ff;
   side_type              out_side_ff;

   always_comb begin
      mx1_in = mag0_ff[0];
      for (int i = 1; i < 3; i++) begin
         if (mag0_ff[i] > mx1_in) begin
            mx1_in = mag0_ff[i];
         end
      end
   end

   always_comb begin
      p2 = msb_pos(mx1_ff);
      for (int i = 0; i < 3; i++) begin
         if (p2 > POS_W'(SCL_W - 1)) begin
            scl2_in[i] = SCL_W'(mag1_ff[i] >> (p2 - POS_W'(SCL_W - 1)));
         end else begin
            scl2_in[i] = SCL_W'(mag1_ff[i] << (POS_W'(SCL_W - 1) - p2));
         end
      end
   end

   always_comb begin
      sq0_in.m    = scl3_ff;
      sq0_in.neg  = neg3_ff;
      sq0_in.zero = zero3_ff;
      sq0_in.side = side3_ff;
      sq0_in.rem  = SUM_W'(sqr3_ff[0]) + SUM_W'(sqr3_ff[1]) + SUM_W'(sqr3_ff[2]);
      sq0_in.root = '0;
   end

   always_comb begin
      dv0_in.len  = sq_ff[NSQ_ST].root;
      dv0_in.neg  = sq_ff[NSQ_ST].neg;
      dv0_in.zero = sq_ff[NSQ_ST].zero;
      dv0_in.side = sq_ff[NSQ_ST].side;
      dv0_in.q    = '0;
      for (int i = 0; i < 3; i++) begin
         num[i] = NUM_W'({sq_ff[NSQ_ST].m[i], 16'h0000})
                + NUM_W'(sq_ff[NSQ_ST].root[ROOT_W-1:1]);
         dv0_in.rem[i] = ROOT_W'(num[i][NUM_W-1:QUO_W]);
         dv0_in.nlo[i] = num[i][QUO_W-1:0];
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (dv_ff[NDIV_ST].zero) begin
            out_unit_in[i] = '0;
         end else if (dv_ff[NDIV_ST].neg[i]) begin
            out_unit_in[i] = UNIT_W'(-{1'b0, dv_ff[NDIV_ST].q[i]});
         end else begin
            out_unit_in[i] = UNIT_W'({1'b0, dv_ff[NDIV_ST].q[i]});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         sqv_ff       <= '0;
         dvv_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         v_ff         <= {v_ff[2:0], in_valid};
         sqv_ff       <= {sqv_ff[NSQ_ST-1:0], v_ff[3]};
         dvv_ff       <= {dvv_ff[NDIV_ST-1:0], sqv_ff[NSQ_ST]};
         out_valid_ff <= dvv_ff[NDIV_ST];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag0_ff  <= in_mag;
         neg0_ff  <= in_neg;
         side0_ff <= in_side;
         mag1_ff  <= mag0_ff;
         mx1_ff   <= mx1_in;
         zero1_ff <= (mx1_in == '0);
         neg1_ff  <= neg0_ff;
         side1_ff <= side0_ff;
         scl2_ff  <= scl2_in;
         zero2_ff <= zero1_ff;
         neg2_ff  <= neg1_ff;
         side2_ff <= side1_ff;
         for (int i = 0; i < 3; i++) begin
            sqr3_ff[i] <= SQR_W'(scl2_ff[i]) * SQR_W'(scl2_ff[i]);
         end
         scl3_ff  <= scl2_ff;
         zero3_ff <= zero2_ff;
         neg3_ff  <= neg2_ff;
         side3_ff <= side2_ff;
         sq_ff[0] <= sq0_in;
         for (int k = 0; k < NSQ_ST; k++) begin
            sq_ff[k+1] <= sqrt_pair(sq_ff[k], k);
         end
         dv_ff[0] <= dv0_in;
         for (int k = 0; k < NDIV_ST; k++) begin
            dv_ff[k+1] <= div_pair(dv_ff[k], k);
         end
         out_unit_ff <= out_unit_in;
         out_zero_ff <= dv_ff[NDIV_ST].zero;
         out_side_ff <= dv_ff[NDIV_ST].side;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_unit  = out_unit_ff;
   assign out_zero  = out_zero_ff;
   assign out_side  = out_side_ff;

endmodule

// File: design/look_at_view_matrix.sv
`timescale 1ns / 1ps
// Right-handed look-at view matrix in signed Q16.16.
// A request on the req_ channel carries the camera position, the target point
// and the up vector. For each request the rsp_ channel delivers four
// responses, rows 0 to 3 of the view matrix, in order; rsp_tlast marks row 3
// and rsp_tuser carries the row index and the degenerate flag.
// When the receiver takes every response, the rows of a matrix follow on
// consecutive cycles. Throughput is set by the single response channel, which
// moves one row a cycle while the receiver takes every response; while the
// output stage holds a matrix, no new request is taken until its last row is.
// Both unit vectors pass a 32-stage normalisation pipeline: magnitude
// scaling, squares, a two-bit-per-stage square root and three
// two-bit-per-stage dividers.
// A synchronous reset empties the pipeline; no response is pending after it.
// When the receiver stalls, the row on the port holds and the whole pipeline
// holds with it, so req_tready falls until the matrix in the output stage
// has its last row taken.
module look_at_view_matrix
   import lav_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // cam_x, cam_y, cam_z, tgt_x, tgt_y, tgt_z, up_x, up_y, up_z
   input  logic [REQ_W-1:0]    req_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // col0, col1, col2, col3
   output logic [RSP_W-1:0]    rsp_tdata,
   // row_index (2 bits), degenerate
   output logic [USER_W-1:0]   rsp_tuser,
   output logic                rsp_tlast
);

   function automatic logic signed [21:0] round_y(input logic signed [36:0] v);
      logic [36:0] m;
      logic [20:0] r;
      m = v[36] ? 37'(-v) : 37'(v);
      r = 21'((m + 37'h8000) >> 16);
      return v[36] ? -$signed({1'b0, r}) : $signed({1'b0, r});
   endfunction

   function automatic logic [IN_W-1:0] trans(input logic signed [55:0] d);
      logic signed [56:0] n;
      logic [56:0]        m;
      logic [40:0]        r;
      n = -{d[55], d};
      m = n[56] ? 57'(-n) : 57'(n);
      r = 41'((m + 57'h8000) >> 16);
      if (!n[56]) begin
         return (r > 41'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : r[31:0];
      end
      return (r >= 41'h0_8000_0000) ? 32'h8000_0000 : 32'(-r[31:0]);
   endfunction

   logic step;

   vec3_type          cam, tgt, upv;
   mag3_type          n1_mag;
   logic [2:0]        n1_neg;
   side_type          n1_side;
   logic signed [32:0] dz [3];
   logic [32:0]       dz_mag [3];

   logic              z_valid, z_zero;
   unit3_type         z_unit;
   side_type          z_side;

   logic              c1_valid_ff;
   logic signed [49:0] c1_p_ff [6];
   vec3_type          c1_pos_ff;
   unit3_type         c1_z_ff;
   logic              c1_deg_ff;
   logic signed [50:0] cx [3];
   mag3_type          n2_mag;
   logic [2:0]        n2_neg;
   side_type          n2_side;

   logic              x_valid, x_zero;
   unit3_type         x_unit;
   side_type          x_side;

   logic              d1_valid_ff, d2_valid_ff, e1_valid_ff, e2_valid_ff;
   logic signed [35:0] d1_p_ff [6];
   vec3_type          d1_pos_ff, d2_pos_ff;
   unit3_type         d1_x_ff, d1_z_ff, d2_x_ff, d2_z_ff, e1_x_ff, e1_z_ff, e2_x_ff, e2_z_ff;
   logic              d1_deg_ff, d2_deg_ff, e1_deg_ff, e2_deg_ff;
   logic signed [21:0] d2_y_ff [3];
   logic signed [21:0] e1_y_ff [3];
   logic signed [21:0] e2_y_ff [3];
   logic signed [53:0] e1_p_ff [9];
   logic signed [55:0] e2_d_ff [3];

   logic              ser_valid_ff, ser_deg_ff;
   logic [1:0]        ser_row_ff;
   vec3_type          ser_x_ff, ser_y_ff, ser_z_ff, ser_t_ff;

   assign step       = !ser_valid_ff || (rsp_tready && ser_row_ff == ROW_LAST);
   assign req_tready = step;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cam[i] = req_tdata[IN_W*i +: IN_W];
         tgt[i] = req_tdata[IN_W*(i+3) +: IN_W];
         upv[i] = req_tdata[IN_W*(i+6) +: IN_W];
         dz[i]  = $signed({cam[i][IN_W-1], cam[i]}) - $signed({tgt[i][IN_W-1], tgt[i]});
         dz_mag[i] = dz[i][32] ? 33'(-dz[i]) : 33'(dz[i]);
         n1_mag[i] = MAG_W'(dz_mag[i]);
         n1_neg[i] = dz[i][32];
      end
      n1_side = {upv, cam};
   end

   lav_norm u_norm_z (
      .clock     (clock),
      .reset     (reset),
      .en        (step),
      .in_valid  (req_tvalid),
      .in_mag    (n1_mag),
      .in_neg    (n1_neg),
      .in_side   (n1_side),
      .out_valid (z_valid),
      .out_unit  (z_unit),
      .out_zero  (z_zero),
      .out_side  (z_side)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_valid_ff  <= 1'b0;
         d1_valid_ff  <= 1'b0;
         d2_valid_ff  <= 1'b0;
         e1_valid_ff  <= 1'b0;
         e2_valid_ff  <= 1'b0;
         ser_valid_ff <= 1'b0;
         ser_row_ff   <= ROW_FIRST;
      end else if (step) begin
         c1_valid_ff  <= z_valid;
         d1_valid_ff  <= x_valid;
         d2_valid_ff  <= d1_valid_ff;
         e1_valid_ff  <= d2_valid_ff;
         e2_valid_ff  <= e1_valid_ff;
         ser_valid_ff <= e2_valid_ff;
         ser_row_ff   <= ROW_FIRST;
      end else if (rsp_tready) begin
         ser_row_ff   <= ser_row_ff + 2'd1;
      end
   end

   always_comb begin
      cx[0] = {c1_p_ff[0][49], c1_p_ff[0]} - {c1_p_ff[1][49], c1_p_ff[1]};
      cx[1] = {c1_p_ff[2][49], c1_p_ff[2]} - {c1_p_ff[3][49], c1_p_ff[3]};
      cx[2] = {c1_p_ff[4][49], c1_p_ff[4]} - {c1_p_ff[5][49], c1_p_ff[5]};
      for (int i = 0; i < 3; i++) begin
         n2_neg[i] = cx[i][50];
         n2_mag[i] = MAG_W'(cx[i][50] ? 51'(-cx[i]) : 51'(cx[i]));
      end
      n2_side = {41'd0, c1_deg_ff, c1_z_ff, c1_pos_ff};
   end

   lav_norm u_norm_x (
      .clock     (clock),
      .reset     (reset),
      .en        (step),
      .in_valid  (c1_valid_ff),
      .in_mag    (n2_mag),
      .in_neg    (n2_neg),
      .in_side   (n2_side),
      .out_valid (x_valid),
      .out_unit  (x_unit),
      .out_zero  (x_zero),
      .out_side  (x_side)
   );

   always_ff @(posedge clock) begin
      if (step) begin
         c1_p_ff[0] <= $signed(z_side[IN_W*4 +: IN_W]) * $signed(z_unit[2]);
         c1_p_ff[1] <= $signed(z_side[IN_W*5 +: IN_W]) * $signed(z_unit[1]);
         c1_p_ff[2] <= $signed(z_side[IN_W*5 +: IN_W]) * $signed(z_unit[0]);
         c1_p_ff[3] <= $signed(z_side[IN_W*3 +: IN_W]) * $signed(z_unit[2]);
         c1_p_ff[4] <= $signed(z_side[IN_W*3 +: IN_W]) * $signed(z_unit[1]);
         c1_p_ff[5] <= $signed(z_side[IN_W*4 +: IN_W]) * $signed(z_unit[0]);
         c1_pos_ff  <= z_side[3*IN_W-1:0];
         c1_z_ff    <= z_unit;
         c1_deg_ff  <= z_zero;

         d1_p_ff[0] <= $signed(x_side[3*IN_W + UNIT_W*1 +: UNIT_W]) * $signed(x_unit[2]);
         d1_p_ff[1] <= $signed(x_side[3*IN_W + UNIT_W*2 +: UNIT_W]) * $signed(x_unit[1]);
         d1_p_ff[2] <= $signed(x_side[3*IN_W + UNIT_W*2 +: UNIT_W]) * $signed(x_unit[0]);
         d1_p_ff[3] <= $signed(x_side[3*IN_W + UNIT_W*0 +: UNIT_W]) * $signed(x_unit[2]);
         d1_p_ff[4] <= $signed(x_side[3*IN_W + UNIT_W*0 +: UNIT_W]) * $signed(x_unit[1]);
         d1_p_ff[5] <= $signed(x_side[3*IN_W + UNIT_W*1 +: UNIT_W]) * $signed(x_unit[0]);
         d1_pos_ff  <= x_side[3*IN_W-1:0];
         d1_z_ff    <= x_side[3*IN_W +: 3*UNIT_W];
         d1_x_ff    <= x_unit;
         d1_deg_ff  <= x_side[3*IN_W + 3*UNIT_W] | x_zero;

         d2_y_ff[0] <= round_y({d1_p_ff[0][35], d1_p_ff[0]} - {d1_p_ff[1][35], d1_p_ff[1]});
         d2_y_ff[1] <= round_y({d1_p_ff[2][35], d1_p_ff[2]} - {d1_p_ff[3][35], d1_p_ff[3]});
         d2_y_ff[2] <= round_y({d1_p_ff[4][35], d1_p_ff[4]} - {d1_p_ff[5][35], d1_p_ff[5]});
         d2_pos_ff  <= d1_pos_ff;
         d2_x_ff    <= d1_x_ff;
         d2_z_ff    <= d1_z_ff;
         d2_deg_ff  <= d1_deg_ff;

         for (int i = 0; i < 3; i++) begin
            e1_p_ff[i]     <= $signed(d2_x_ff[i]) * $signed(d2_pos_ff[i]);
            e1_p_ff[3 + i] <= d2_y_ff[i] * $signed(d2_pos_ff[i]);
            e1_p_ff[6 + i] <= $signed(d2_z_ff[i]) * $signed(d2_pos_ff[i]);
            e1_y_ff[i]     <= d2_y_ff[i];
            e2_y_ff[i]     <= e1_y_ff[i];
            e2_d_ff[i]     <= 56'(e1_p_ff[3*i]) + 56'(e1_p_ff[3*i + 1])
                            + 56'(e1_p_ff[3*i + 2]);
         end
         e1_x_ff   <= d2_x_ff;
         e1_z_ff   <= d2_z_ff;
         e1_deg_ff <= d2_deg_ff;
         e2_x_ff   <= e1_x_ff;
         e2_z_ff   <= e1_z_ff;
         e2_deg_ff <= e1_deg_ff;

         for (int i = 0; i < 3; i++) begin
            ser_x_ff[i] <= IN_W'($signed(e2_x_ff[i]));
            ser_y_ff[i] <= IN_W'(e2_y_ff[i]);
            ser_z_ff[i] <= IN_W'($signed(e2_z_ff[i]));
            ser_t_ff[i] <= trans(e2_d_ff[i]);
         end
         ser_deg_ff <= e2_deg_ff;
      end
   end

   always_comb begin
      case (ser_row_ff)
         2'd0: rsp_tdata = {32'h0, ser_z_ff[0], ser_y_ff[0], ser_x_ff[0]};
         2'd1: rsp_tdata = {32'h0, ser_z_ff[1], ser_y_ff[1], ser_x_ff[1]};
         2'd2: rsp_tdata = {32'h0, ser_z_ff[2], ser_y_ff[2], ser_x_ff[2]};
         default: rsp_tdata = {ONE_Q16, ser_t_ff[2], ser_t_ff[1], ser_t_ff[0]};
      endcase
   end

   assign rsp_tvalid = ser_valid_ff;
   assign rsp_tuser  = {ser_deg_ff, ser_row_ff};
   assign rsp_tlast  = (ser_row_ff == ROW_LAST);

endmodule

// File: design/lav_checker.sv
`timescale 1ns / 1ps

module lav_checker
   import lav_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic [REQ_W-1:0]  req_tdata,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [RSP_W-1:0]  rsp_tdata,
   input logic [USER_W-1:0] rsp_tuser,
   input logic              rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("Stalled response changed.");

   a_row_next: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid
         && rsp_tuser[1:0] == $past(rsp_tuser[1:0]) + 2'd1
         && rsp_tuser[2] == $past(rsp_tuser[2]))
      else $error("Matrix rows out of sequence.");

   a_row_first: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid || rsp_tuser[1:0] == ROW_FIRST)
      else $error("New matrix does not start at row 0.");

   a_last_col: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tlast == (rsp_tuser[1:0] == ROW_LAST)
         && rsp_tdata[RSP_W-1 -: IN_W] == (rsp_tlast ? ONE_Q16 : 32'h0))
      else $error("Last column or last flag wrong.");

endmodule

bind look_at_view_matrix lav_checker u_lav_checker (.*);

// File: tb/tb_look_at_view_matrix.sv
`timescale 1ns / 1ps

module tb_look_at_view_matrix;
   import lav_pkg::*;

   typedef longint trio_type [3];

   typedef struct packed {
      logic [1:0]       row;
      logic [3:0][31:0] cols;
      logic             degen;
      logic             last;
   } matrix_row_type;

   class view_matrix_board;
      matrix_row_type rows_due[$];
      int             errors;

      function longint magnitude(longint v);
         return (v < 0) ? -v : v;
      endfunction

      function longint round_q16(longint v);
         longint m;
         m = (magnitude(v) + 64'h8000) >>> 16;
         return (v < 0) ? -m : m;
      endfunction

      function longint clamp32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function longint unsigned root_floor(longint unsigned n);
         longint unsigned res, bitv;
         res  = 0;
         bitv = 64'd1 << 62;
         while (bitv > n) bitv = bitv >> 2;
         while (bitv != 0) begin
            if (n >= res + bitv) begin
               n   = n - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
         return res;
      endfunction

      function bit unit_vector(trio_type v, output trio_type o);
         longint unsigned m [3];
         longint unsigned mx, total, len, q;
         mx = 0;
         for (int i = 0; i < 3; i++) begin
            m[i] = magnitude(v[i]);
            if (m[i] > mx) mx = m[i];
         end
         if (mx == 0) begin
            o = '{0, 0, 0};
            return 1'b1;
         end
         while (mx >= (64'd1 << 30)) begin
            mx = mx >> 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
         end
         while (mx < (64'd1 << 29)) begin
            mx = mx << 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
         end
         total = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
         len   = root_floor(total);
         for (int i = 0; i < 3; i++) begin
            q    = (m[i] * 64'd65536 + len / 2) / len;
            o[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
         end
         return 1'b0;
      endfunction

      function trio_type cross3(trio_type a, trio_type b);
         trio_type o;
         o[0] = a[1] * b[2] - a[2] * b[1];
         o[1] = a[2] * b[0] - a[0] * b[2];
         o[2] = a[0] * b[1] - a[1] * b[0];
         return o;
      endfunction

      function longint translation(trio_type a, trio_type p);
         return clamp32(round_q16(-(a[0] * p[0] + a[1] * p[1] + a[2] * p[2])));
      endfunction

      function void note_request(logic [REQ_W-1:0] data);
         trio_type       pos, up, diff, zax, xax, yax, t;
         logic           degen;
         matrix_row_type r;
         for (int i = 0; i < 3; i++) begin
            pos[i]  = longint'($signed(data[i*32 +: 32]));
            diff[i] = pos[i] - longint'($signed(data[(3+i)*32 +: 32]));
            up[i]   = longint'($signed(data[(6+i)*32 +: 32]));
         end
         degen = unit_vector(diff, zax);
         t = cross3(up, zax);
         if (unit_vector(t, xax)) degen = 1'b1;
         t = cross3(zax, xax);
         for (int i = 0; i < 3; i++) yax[i] = round_q16(t[i]);
         for (int k = 0; k < 4; k++) begin
            r.row   = k[1:0];
            r.degen = degen;
            r.last  = (r.row == ROW_LAST);
            if (k < 3) begin
               r.cols[0] = 32'(clamp32(xax[k]));
               r.cols[1] = 32'(clamp32(yax[k]));
               r.cols[2] = 32'(clamp32(zax[k]));
               r.cols[3] = '0;
            end else begin
               r.cols[0] = 32'(translation(xax, pos));
               r.cols[1] = 32'(translation(yax, pos));
               r.cols[2] = 32'(translation(zax, pos));
               r.cols[3] = ONE_Q16;
            end
            rows_due.push_back(r);
         end
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
         errors++;
      endtask

      task check_row(matrix_row_type got);
         matrix_row_type want;
         if (rows_due.size() == 0) begin
            report("unexpected row", 32'(got.row), 32'hx);
            return;
         end
         want = rows_due.pop_front();
         if (got.row !== want.row) report("row_index", 32'(got.row), 32'(want.row));
         for (int c = 0; c < 4; c++)
            if (got.cols[c] !== want.cols[c])
               report($sformatf("col%0d", c), got.cols[c], want.cols[c]);
         if (got.degen !== want.degen) report("degenerate", 32'(got.degen), 32'(want.degen));
         if (got.last !== want.last) report("last_row", 32'(got.last), 32'(want.last));
      endtask
   endclass

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic [USER_W-1:0] rsp_tuser;
   logic             rsp_tlast;

   view_matrix_board board;
   int               send_idle_pct;
   int               sink_stall_pct;
   longint           cycles;

   look_at_view_matrix uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= sink_stall_pct);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("Regression FAIL");
         $finish;
      end
      if (!reset) begin
         if (req_tvalid && req_tready) board.note_request(req_tdata);
         if (rsp_tvalid && rsp_tready)
            board.check_row({rsp_tuser[1:0], rsp_tdata, rsp_tuser[2], rsp_tlast});
      end
   end

   task automatic send_view(logic [31:0] cx, cy, cz, tx, ty, tz, ux, uy, uz);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= {$urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom, $urandom};
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {uz, uy, ux, tz, ty, tx, cz, cy, cx};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick_coord(int mode);
      case (mode)
         0: return $urandom;
         1: return 32'($signed($urandom_range(2097152)) - 1048576);
         default: return 32'($signed($urandom_range(2048)) - 1024) << 16;
      endcase
   endfunction

   task automatic send_random(int n);
      logic [31:0] c [9];
      int          mode;
      for (int k = 0; k < n; k++) begin
         mode = $urandom_range(2);
         for (int i = 0; i < 9; i++) c[i] = pick_coord(mode);
         case ($urandom_range(9))
            0: begin c[3] = c[0]; c[4] = c[1]; c[5] = c[2]; end
            1: begin c[6] = c[0] - c[3]; c[7] = c[1] - c[4]; c[8] = c[2] - c[5]; end
            2: begin c[6] = 0; c[7] = 0; c[8] = 0; end
            default: ;
         endcase
         send_view(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8]);
      end
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      while (board.rows_due.size() != 0) @(negedge clock);
   endtask

   localparam logic [31:0] ONE  = 32'h0001_0000;
   localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
   localparam logic [31:0] MINV = 32'h8000_0000;

   initial begin
      board          = new();
      send_idle_pct  = 0;
      sink_stall_pct = 0;
      cycles         = 0;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      rsp_tready     = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_view(0, 0, 5*ONE, 0, 0, 0, 0, ONE, 0);
      send_view(0, 0, 0, 0, 0, 0, 0, ONE, 0);
      send_view(0, 0, 5*ONE, 0, 0, 0, 0, 0, ONE);
      send_view(ONE, 2*ONE, 3*ONE, ONE, 2*ONE, 3*ONE, 0, 0, 0);
      send_view(ONE, 0, 0, 0, 0, 0, 0, 0, 0);
      send_view(MAXV, MAXV, MAXV, MINV, MINV, MINV, MAXV, MINV, MAXV);
      send_view(MINV, MINV, MINV, MAXV, MAXV, MAXV, MINV, MAXV, MINV);
      send_view(MAXV, MAXV, MAXV, 0, 0, 0, 0, ONE, 0);
      send_view(MINV, MINV, MINV, 0, 0, 0, 0, ONE, 0);
      send_view(MAXV, MINV, MAXV, 0, 0, 0, ONE, 0, 0);
      send_view(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 1, 0, 0);
      send_view(1, 0, 0, 0, 0, 0, 0, 1, 0);
      send_view(MAXV, 0, 0, MINV, 0, 0, 0, MAXV, 0);
      send_view(3*ONE, 4*ONE, 0, 0, 0, 0, 0, 0, ONE);
      send_view(MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV);
      send_view(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV);
      send_random(45);
      drain();

      send_idle_pct = 69;
      send_random(45);
      drain();

      send_idle_pct  = 0;
      sink_stall_pct = 69;
      send_random(45);
      drain();

      send_idle_pct  = 23;
      sink_stall_pct = 23;
      send_random(45);
      drain();

      repeat (150) @(negedge clock);
      if (board.errors == 0 && board.rows_due.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
